FILE: rtl/x86_page_table_walker_core_assert.svh
// Assertion macros shared by the page walker RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef X86_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`define X86_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PTW_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("ptw check failed");
`define PTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptw check failed");
`else
`define PTW_ASSERT(label, clk, rst, expr)
`define PTW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/ptw_pkg.sv
// Types and constants of the page table walker.
// No dependencies; used by the channel interfaces and the core.
package ptw_pkg;

   localparam int PHYS_ADDR_BITS = 52;
   localparam int PA_W           = 52;
   localparam int VA_W           = 57;
   localparam int ENTRY_W        = 64;
   localparam int CSR_DATA_W     = 52;
   localparam int IDX_W          = 9;

   localparam logic [PA_W-1:0] PA_MASK  = PA_W'((64'd1 << PHYS_ADDR_BITS) - 64'd1);
   localparam logic [PA_W-1:0] FRAME_4K = PA_MASK & ~PA_W'(64'hfff);
   localparam logic [PA_W-1:0] FRAME_2M = PA_MASK & ~PA_W'(64'h1fffff);
   localparam logic [PA_W-1:0] FRAME_1G = PA_MASK & ~PA_W'(64'h3fffffff);

   localparam int PRESENT_POS = 0;
   localparam int LARGE_POS   = 7;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SIZE_4K = 2'd0,
      SIZE_2M = 2'd1,
      SIZE_1G = 2'd2
   } size_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NOT_PRESENT = 2'd1,
      STATUS_UNSUPPORTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_TABLE_ROOT     = 2'd0,
      CSR_FIVE_LEVEL     = 2'd1,
      CSR_PAGING_ENABLED = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      LVL_NONE = 3'd0,
      LVL_PT   = 3'd1,
      LVL_PD   = 3'd2,
      LVL_PDPT = 3'd3,
      LVL_PML4 = 3'd4,
      LVL_PML5 = 3'd5
   } level_type;

   typedef enum logic {
      OP_TRANSLATE = 1'b0,
      OP_ENTRY     = 1'b1
   } op_type;

   typedef struct packed {
      kind_type          kind;
      logic [PA_W-1:0]   read_address;
      logic [PA_W-1:0]   physical_address;
      size_type          page_size;
      status_type        status;
   } rsp_type;

endpackage

FILE: rtl/ptw_if.sv
// Valid/ready channel interfaces of the page table walker.
// Depends on ptw_pkg for field widths.
interface ptw_req_if;
   import ptw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [VA_W-1:0]      virtual_address;
   logic [ENTRY_W-1:0]   table_entry;

   modport source (output valid, output operation, output virtual_address,
                   output table_entry, input ready);
   modport sink   (input valid, input operation, input virtual_address,
                   input table_entry, output ready);
endinterface

interface ptw_rsp_if;
   import ptw_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [PA_W-1:0]   read_address;
   logic [PA_W-1:0]   physical_address;
   logic [1:0]        page_size;
   logic [1:0]        status;

   modport source (output valid, output kind, output read_address,
                   output physical_address, output page_size, output status,
                   input ready);
   modport sink   (input valid, input kind, input read_address,
                   input physical_address, input page_size, input status,
                   output ready);
endinterface

FILE: rtl/x86_page_table_walker_core.sv
// A result beat is registered and is valid in the cycle after its request beat is accepted.
// Throughput: one beat per cycle; decode of an entry is masks and muxes between
// the request port and the result register, so walk speed is set by memory latency.
// The request side stalls only while a result beat waits on rsp ready.
// Reset (synchronous, active high) clears config, walk state and result valid.
// Depends on ptw_pkg, ptw_if.sv and x86_page_table_walker_core_assert.svh.
`include "x86_page_table_walker_core_assert.svh"

module x86_page_table_walker_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [ptw_pkg::CSR_DATA_W-1:0] csr_write_data,
   ptw_req_if.sink                       req_chan,
   ptw_rsp_if.source                     rsp_chan
);
   import ptw_pkg::*;

   logic [PA_W-1:0]  table_root_ff;
   logic             five_level_ff;
   logic             paging_enabled_ff;

   logic             busy_ff, busy_in;
   level_type        walk_level_ff, walk_level_in;
   logic [VA_W-1:0]  held_address_ff, held_address_in;

   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             has_result;
   logic             req_fire;

   level_type        lvl;
   level_type        next_lvl;
   logic             present;
   logic             ps_bit;
   logic [PA_W-1:0]  entry_pa;

   function automatic logic [PA_W-1:0] entry_address(input logic [PA_W-1:0] base,
                                                     input level_type level,
                                                     input logic [VA_W-1:0] va);
      logic [IDX_W-1:0] idx;
      unique case (level)
         LVL_PML5: idx = va[56:48];
         LVL_PML4: idx = va[47:39];
         LVL_PDPT: idx = va[38:30];
         LVL_PD:   idx = va[29:21];
         default:  idx = va[20:12];
      endcase
      return (base & FRAME_4K) | (PA_W'(idx) << 3);
   endfunction

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         table_root_ff     <= '0;
         five_level_ff     <= 1'b0;
         paging_enabled_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TABLE_ROOT:     table_root_ff     <= csr_write_data;
            CSR_FIVE_LEVEL:     five_level_ff     <= csr_write_data[0];
            CSR_PAGING_ENABLED: paging_enabled_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign present  = req_chan.table_entry[PRESENT_POS];
   assign ps_bit   = req_chan.table_entry[LARGE_POS];
   assign entry_pa = req_chan.table_entry[PA_W-1:0];

   // levels outside PT..PML5 are handled as PT
   always_comb begin
      if (walk_level_ff >= LVL_PT && walk_level_ff <= LVL_PML5) begin
         lvl = walk_level_ff;
      end else begin
         lvl = LVL_PT;
      end
      unique case (lvl)
         LVL_PML5: next_lvl = LVL_PML4;
         LVL_PML4: next_lvl = LVL_PDPT;
         LVL_PDPT: next_lvl = LVL_PD;
         LVL_PD:   next_lvl = LVL_PT;
         default:  next_lvl = LVL_NONE;
      endcase
   end

   always_comb begin
      busy_in         = busy_ff;
      walk_level_in   = walk_level_ff;
      held_address_in = held_address_ff;
      has_result      = 1'b1;
      rsp_in          = '{kind: KIND_READ, read_address: '0, physical_address: '0,
                          page_size: SIZE_4K, status: STATUS_OK};
      if (req_chan.operation == OP_TRANSLATE) begin
         if (!paging_enabled_ff) begin
            busy_in       = 1'b0;
            walk_level_in = LVL_NONE;
            rsp_in.kind   = KIND_ERROR;
            rsp_in.status = STATUS_UNSUPPORTED;
         end else begin
            busy_in         = 1'b1;
            held_address_in = req_chan.virtual_address;
            walk_level_in   = five_level_ff ? LVL_PML5 : LVL_PML4;
            rsp_in.read_address = entry_address(table_root_ff, walk_level_in,
                                                req_chan.virtual_address);
         end
      end else if (!busy_ff) begin
         has_result = 1'b0;
      end else if (!present) begin
         busy_in       = 1'b0;
         walk_level_in = LVL_NONE;
         rsp_in.kind   = KIND_ERROR;
         rsp_in.status = STATUS_NOT_PRESENT;
      end else if (lvl == LVL_PDPT && ps_bit) begin
         busy_in                 = 1'b0;
         walk_level_in           = LVL_NONE;
         rsp_in.kind             = KIND_DONE;
         rsp_in.page_size        = SIZE_1G;
         rsp_in.physical_address = (entry_pa & FRAME_1G) |
                                   (PA_W'(held_address_ff[29:0]) & PA_MASK);
      end else if (lvl == LVL_PD && ps_bit) begin
         busy_in                 = 1'b0;
         walk_level_in           = LVL_NONE;
         rsp_in.kind             = KIND_DONE;
         rsp_in.page_size        = SIZE_2M;
         rsp_in.physical_address = (entry_pa & FRAME_2M) |
                                   (PA_W'(held_address_ff[20:0]) & PA_MASK);
      end else if (lvl == LVL_PT) begin
         busy_in                 = 1'b0;
         walk_level_in           = LVL_NONE;
         rsp_in.kind             = KIND_DONE;
         rsp_in.page_size        = SIZE_4K;
         rsp_in.physical_address = (entry_pa & FRAME_4K) |
                                   (PA_W'(held_address_ff[11:0]) & PA_MASK);
      end else begin
         walk_level_in       = next_lvl;
         rsp_in.read_address = entry_address(entry_pa, next_lvl, held_address_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         walk_level_ff   <= LVL_NONE;
         held_address_ff <= '0;
      end else if (req_fire) begin
         busy_ff         <= busy_in;
         walk_level_ff   <= walk_level_in;
         held_address_ff <= held_address_in;
      end
   end

   // result valid flag; reloads whenever the request side can move
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         rsp_valid_ff <= req_fire && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.kind             = rsp_ff.kind;
   assign rsp_chan.read_address     = rsp_ff.read_address;
   assign rsp_chan.physical_address = rsp_ff.physical_address;
   assign rsp_chan.page_size        = rsp_ff.page_size;
   assign rsp_chan.status           = rsp_ff.status;

   `PTW_ASSERT(a_busy_level, clock, reset,
      !busy_ff || (walk_level_ff >= LVL_PT && walk_level_ff <= LVL_PML5))
   `PTW_ASSERT_NEXT(a_start_walk, clock, reset,
      req_fire && req_chan.operation == OP_TRANSLATE && paging_enabled_ff,
      rsp_valid_ff && rsp_ff.kind == KIND_READ && busy_ff)
   `PTW_ASSERT_NEXT(a_idle_entry_silent, clock, reset,
      req_fire && req_chan.operation == OP_ENTRY && !busy_ff,
      !rsp_valid_ff)
   `PTW_ASSERT(a_error_ends_walk, clock, reset,
      !(rsp_valid_ff && rsp_ff.kind == KIND_ERROR) || !busy_ff)

endmodule
